>>> rtl/rrts_pkg.sv
// rrts_pkg: shared codes and constants of the round-robin thread scheduler
// depends on nothing
`timescale 1ns / 1ps

package rrts_pkg;

    // event kinds carried by an input word
    localparam logic [2:0] KIND_CREATE = 3'd0;
    localparam logic [2:0] KIND_YIELD  = 3'd1;
    localparam logic [2:0] KIND_SLEEP  = 3'd2;
    localparam logic [2:0] KIND_EXIT   = 3'd3;
    localparam logic [2:0] KIND_TICK   = 3'd4;

    // result status codes
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_SLOT = 2'd1;
    localparam logic [1:0] STAT_REFUSED = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_PREEMPT = 2'd0;
    localparam logic [1:0] CFG_SLICE   = 2'd1;

    localparam logic [15:0] SLICE_RESET = 16'd20;

    typedef enum logic [9:0] {
        S_IDLE     = 10'b00_0000_0001,
        S_FIND     = 10'b00_0000_0010,
        S_SCHED    = 10'b00_0000_0100,
        S_POP      = 10'b00_0000_1000,
        S_INS      = 10'b00_0001_0000,
        S_INS_CMP  = 10'b00_0010_0000,
        S_WAKE     = 10'b00_0100_0000,
        S_WAKE_CMP = 10'b00_1000_0000,
        S_TICKEND  = 10'b01_0000_0000,
        S_OUT      = 10'b10_0000_0000
    } t_state;

endpackage

>>> rtl/rrts_ram.sv
// rrts_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`timescale 1ns / 1ps

module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/round_robin_thread_scheduler_unit.sv
// round_robin_thread_scheduler_unit: top level of the thread scheduler
// depends on rrts_pkg and rrts_ram
`timescale 1ns / 1ps

// Round-robin thread scheduler over MAX_THREADS slots. Slot 0 (main) runs after
// reset, slot 1 is the idle thread and is picked only when the run queue is empty.
// Each input word is one event (create, yield, sleep until tick, exit, timer
// tick) and gives exactly one result word. The run queue is a circular fifo in
// one ram, the sleep list a circular list sorted by wake tick in a second ram.
// Items are handled one at a time; each ends by loading the result register.
// The steps per kind:
//   schedule step: direct with an empty run queue, else a head read
//   yield/exit: the schedule step (at most one run queue read for the new head)
//   create: a slot scan from slot 0 up to the lowest free slot; the scan
//           runs over every slot when no slot is free
//   sleep: a read then a move of one entry per sleeper with a later wake
//          tick, the insert, then the schedule step
//   tick: a read and a pop per woken sleeper, plus a schedule step if one
//         follows; refused sleep/exit and unknown kinds go straight to the result
// The sleep walk and the tick walk are bound by the single ram read port.
// A finished result sits in an output register, so the next event is taken
// while it waits. Config writes are always accepted.
module round_robin_thread_scheduler_unit #(
    parameter int MAX_THREADS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // event channel
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [2:0]  i_kind,
    input  logic [63:0] i_wake_tick,
    input  logic [63:0] i_now_tick,
    // result channel
    output logic        o_valid,
    input  logic        i_ready,
    output logic [3:0]  o_running_thread,
    output logic [3:0]  o_previous_thread,
    output logic        o_switched,
    output logic [3:0]  o_created_thread,
    output logic [1:0]  o_status,
    output logic [4:0]  o_woken_count,
    output logic [4:0]  o_live_threads,
    // configuration write channel
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import rrts_pkg::*;

    localparam int SW = $clog2(MAX_THREADS);
    localparam int CW = $clog2(MAX_THREADS + 1);
    localparam int EW = 64 + SW;
    localparam logic [SW-1:0] IDLE_SLOT = SW'(1);
    localparam logic [SW-1:0] LAST_SLOT = SW'(MAX_THREADS - 1);
    localparam logic [CW-1:0] FULL     = CW'(MAX_THREADS);
    localparam logic [SW:0]   MODV     = (SW+1)'(MAX_THREADS);

    t_state r_state, n_state;

    // latched event
    logic [63:0] r_wake, n_wake;
    logic [63:0] r_now, n_now;

    // scheduler state
    logic [SW-1:0]          r_cur, n_cur;
    logic [SW-1:0]          r_prev, n_prev;
    logic [MAX_THREADS-1:0] r_alloc, n_alloc;
    logic [CW-1:0]          r_live, n_live;
    logic [SW-1:0]          r_run_head, n_run_head;
    logic [CW-1:0]          r_run_fill, n_run_fill;
    logic [SW-1:0]          r_slp_head, n_slp_head;
    logic [CW-1:0]          r_slp_fill, n_slp_fill;
    logic [15:0]            r_slice, n_slice;
    logic                   r_push, n_push;
    logic [CW-1:0]          r_k, n_k;
    logic [SW-1:0]          r_scan, n_scan;

    // per-event result fields
    logic [SW-1:0] r_created, n_created;
    logic [1:0]    r_status, n_status;
    logic [CW-1:0] r_woken, n_woken;

    // configuration
    logic        r_preempt, n_preempt;
    logic [15:0] r_slice_ticks, n_slice_ticks;

    // output register
    logic          r_out_vld, n_out_vld;
    logic [SW-1:0] r_o_run, n_o_run;
    logic [SW-1:0] r_o_prev, n_o_prev;
    logic          r_o_sw, n_o_sw;
    logic [SW-1:0] r_o_created, n_o_created;
    logic [1:0]    r_o_status, n_o_status;
    logic [CW-1:0] r_o_woken, n_o_woken;
    logic [CW-1:0] r_o_live, n_o_live;

    // ram ports
    logic          run_we, run_re;
    logic [SW-1:0] run_waddr, run_raddr;
    logic [SW-1:0] run_wdata, run_rdata;
    logic          slp_we, slp_re;
    logic [SW-1:0] slp_waddr, slp_raddr;
    logic [EW-1:0] slp_wdata, slp_rdata;

    // derived addresses
    logic [SW:0]   run_wr_sum, slp_k_sum, slp_km1_sum;
    logic [SW-1:0] run_wr_idx, slp_k_idx, slp_km1_idx;
    logic [SW-1:0] slp_rd_slot;
    logic [63:0]   slp_rd_wake;
    logic          do_push;
    logic          accept;
    logic          out_load;
    logic [15:0]   slice_dec;

    rrts_ram #(.WIDTH(SW), .DEPTH(MAX_THREADS)) u_run_ram (
        .i_clk   (i_clk),
        .i_we    (run_we),
        .i_waddr (run_waddr),
        .i_wdata (run_wdata),
        .i_re    (run_re),
        .i_raddr (run_raddr),
        .o_rdata (run_rdata)
    );

    rrts_ram #(.WIDTH(EW), .DEPTH(MAX_THREADS)) u_sleep_ram (
        .i_clk   (i_clk),
        .i_we    (slp_we),
        .i_waddr (slp_waddr),
        .i_wdata (slp_wdata),
        .i_re    (slp_re),
        .i_raddr (slp_raddr),
        .o_rdata (slp_rdata)
    );

    assign o_ready     = (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = i_valid && o_ready;

    // circular addresses: head + offset, wrapped once
    always_comb begin
        run_wr_sum = (SW+1)'(r_run_head) + (SW+1)'(r_run_fill);
        if (run_wr_sum >= MODV) begin
            run_wr_sum = run_wr_sum - MODV;
        end
        run_wr_idx = run_wr_sum[SW-1:0];

        slp_k_sum = (SW+1)'(r_slp_head) + (SW+1)'(r_k);
        if (slp_k_sum >= MODV) begin
            slp_k_sum = slp_k_sum - MODV;
        end
        slp_k_idx = slp_k_sum[SW-1:0];

        slp_km1_sum = (SW+1)'(r_slp_head) + (SW+1)'(r_k - CW'(1));
        if (slp_km1_sum >= MODV) begin
            slp_km1_sum = slp_km1_sum - MODV;
        end
        slp_km1_idx = slp_km1_sum[SW-1:0];
    end

    assign slp_rd_slot = slp_rdata[SW-1:0];
    assign slp_rd_wake = slp_rdata[SW +: 64];
    assign do_push     = r_push && (r_run_fill != FULL);
    assign slice_dec   = r_slice - 16'd1;
    assign out_load    = (r_state == S_OUT) && (!r_out_vld || i_ready);

    always_comb begin
        n_state       = r_state;
        n_wake        = r_wake;
        n_now         = r_now;
        n_cur         = r_cur;
        n_prev        = r_prev;
        n_alloc       = r_alloc;
        n_live        = r_live;
        n_run_head    = r_run_head;
        n_run_fill    = r_run_fill;
        n_slp_head    = r_slp_head;
        n_slp_fill    = r_slp_fill;
        n_slice       = r_slice;
        n_push        = r_push;
        n_k           = r_k;
        n_scan        = r_scan;
        n_created     = r_created;
        n_status      = r_status;
        n_woken       = r_woken;
        n_preempt     = r_preempt;
        n_slice_ticks = r_slice_ticks;

        run_we    = 1'b0;
        run_waddr = run_wr_idx;
        run_wdata = r_cur;
        run_re    = 1'b0;
        run_raddr = r_run_head;
        slp_we    = 1'b0;
        slp_waddr = slp_k_idx;
        slp_wdata = {r_wake, r_cur};
        slp_re    = 1'b0;
        slp_raddr = slp_km1_idx;

        // config writes land at any time
        if (i_cfg_valid) begin
            if (i_cfg_index == CFG_PREEMPT) begin
                n_preempt = i_cfg_data[0];
            end else if (i_cfg_index == CFG_SLICE) begin
                n_slice_ticks = i_cfg_data;
            end
        end

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_wake    = i_wake_tick;
                    n_now     = i_now_tick;
                    n_prev    = r_cur;
                    n_created = '0;
                    n_status  = STAT_OK;
                    n_woken   = '0;
                    n_push    = (r_cur != IDLE_SLOT);
                    n_scan    = '0;
                    n_k       = r_slp_fill;
                    if (i_kind == KIND_CREATE) begin
                        n_state = S_FIND;
                    end else if (i_kind == KIND_YIELD) begin
                        n_state = S_SCHED;
                    end else if (i_kind == KIND_SLEEP) begin
                        n_push = 1'b0;
                        if (r_cur == IDLE_SLOT) begin
                            n_status = STAT_REFUSED;
                            n_state  = S_OUT;
                        end else if (r_slp_fill == FULL) begin
                            n_state = S_SCHED;
                        end else begin
                            n_state = S_INS;
                        end
                    end else if (i_kind == KIND_EXIT) begin
                        n_push = 1'b0;
                        if (r_cur == IDLE_SLOT) begin
                            n_status = STAT_REFUSED;
                            n_state  = S_OUT;
                        end else begin
                            n_alloc[r_cur] = 1'b0;
                            if (r_live != '0) begin
                                n_live = r_live - CW'(1);
                            end
                            n_state = S_SCHED;
                        end
                    end else if (i_kind == KIND_TICK) begin
                        n_state = S_WAKE;
                    end else begin
                        n_state = S_OUT;
                    end
                end
            end

            // one slot per cycle, lowest free wins
            S_FIND: begin
                if (!r_alloc[r_scan]) begin
                    n_alloc[r_scan] = 1'b1;
                    n_live          = r_live + CW'(1);
                    n_created       = r_scan;
                    if (r_run_fill != FULL) begin
                        run_we     = 1'b1;
                        run_wdata  = r_scan;
                        n_run_fill = r_run_fill + CW'(1);
                    end
                    n_state = S_OUT;
                end else if (r_scan == LAST_SLOT) begin
                    n_status = STAT_NO_SLOT;
                    n_state  = S_OUT;
                end else begin
                    n_scan = r_scan + SW'(1);
                end
            end

            // requeue the old thread and fetch the head; with an empty queue the old thread stays or idle runs
            S_SCHED: begin
                if (r_run_fill == '0) begin
                    n_cur   = r_push ? r_cur : IDLE_SLOT;
                    n_slice = r_slice_ticks;
                    n_state = S_OUT;
                end else begin
                    run_re = 1'b1;
                    if (do_push) begin
                        run_we = 1'b1;
                    end
                    n_run_fill = r_run_fill + CW'(do_push) - CW'(1);
                    n_run_head = (r_run_head == LAST_SLOT) ? '0 : r_run_head + SW'(1);
                    n_state    = S_POP;
                end
            end

            S_POP: begin
                n_cur   = run_rdata;
                n_slice = r_slice_ticks;
                n_state = S_OUT;
            end

            // walk back from the tail, moving later sleepers up one place
            S_INS: begin
                if (r_k == '0) begin
                    slp_we     = 1'b1;
                    n_slp_fill = r_slp_fill + CW'(1);
                    n_state    = S_SCHED;
                end else begin
                    slp_re  = 1'b1;
                    n_state = S_INS_CMP;
                end
            end

            S_INS_CMP: begin
                slp_we = 1'b1;
                if (slp_rd_wake > r_wake) begin
                    slp_wdata = slp_rdata;
                    n_k       = r_k - CW'(1);
                    n_state   = S_INS;
                end else begin
                    n_slp_fill = r_slp_fill + CW'(1);
                    n_state    = S_SCHED;
                end
            end

            // pop due sleepers from the head of the list
            S_WAKE: begin
                if (r_slp_fill == '0) begin
                    n_state = S_TICKEND;
                end else begin
                    slp_re    = 1'b1;
                    slp_raddr = r_slp_head;
                    n_state   = S_WAKE_CMP;
                end
            end

            S_WAKE_CMP: begin
                if (slp_rd_wake <= r_now) begin
                    n_slp_head = (r_slp_head == LAST_SLOT) ? '0 : r_slp_head + SW'(1);
                    n_slp_fill = r_slp_fill - CW'(1);
                    n_woken    = r_woken + CW'(1);
                    if (r_run_fill != FULL) begin
                        run_we     = 1'b1;
                        run_wdata  = slp_rd_slot;
                        n_run_fill = r_run_fill + CW'(1);
                    end
                    n_state = S_WAKE;
                end else begin
                    n_state = S_TICKEND;
                end
            end

            // idle gives way to a queued thread, or with preemption on the slice runs down
            S_TICKEND: begin
                n_state = S_OUT;
                if (r_cur == IDLE_SLOT) begin
                    if (r_run_fill != '0) begin
                        n_state = S_SCHED;
                    end
                end else if (r_preempt) begin
                    n_slice = slice_dec;
                    if (slice_dec == 16'd0) begin
                        n_state = S_SCHED;
                    end
                end
            end

            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result register
    always_comb begin
        n_out_vld   = r_out_vld && !i_ready;
        n_o_run     = r_o_run;
        n_o_prev    = r_o_prev;
        n_o_sw      = r_o_sw;
        n_o_created = r_o_created;
        n_o_status  = r_o_status;
        n_o_woken   = r_o_woken;
        n_o_live    = r_o_live;
        if (out_load) begin
            n_out_vld   = 1'b1;
            n_o_run     = r_cur;
            n_o_prev    = r_prev;
            n_o_sw      = (r_cur != r_prev);
            n_o_created = r_created;
            n_o_status  = r_status;
            n_o_woken   = r_woken;
            n_o_live    = r_live;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_cur         <= '0;
            r_alloc       <= MAX_THREADS'(3);
            r_live        <= CW'(2);
            r_run_head    <= '0;
            r_run_fill    <= '0;
            r_slp_head    <= '0;
            r_slp_fill    <= '0;
            r_slice       <= SLICE_RESET;
            r_preempt     <= 1'b0;
            r_slice_ticks <= SLICE_RESET;
            r_out_vld     <= 1'b0;
        end else begin
            r_state       <= n_state;
            r_cur         <= n_cur;
            r_alloc       <= n_alloc;
            r_live        <= n_live;
            r_run_head    <= n_run_head;
            r_run_fill    <= n_run_fill;
            r_slp_head    <= n_slp_head;
            r_slp_fill    <= n_slp_fill;
            r_slice       <= n_slice;
            r_preempt     <= n_preempt;
            r_slice_ticks <= n_slice_ticks;
            r_out_vld     <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_wake      <= n_wake;
        r_now       <= n_now;
        r_prev      <= n_prev;
        r_push      <= n_push;
        r_k         <= n_k;
        r_scan      <= n_scan;
        r_created   <= n_created;
        r_status    <= n_status;
        r_woken     <= n_woken;
        r_o_run     <= n_o_run;
        r_o_prev    <= n_o_prev;
        r_o_sw      <= n_o_sw;
        r_o_created <= n_o_created;
        r_o_status  <= n_o_status;
        r_o_woken   <= n_o_woken;
        r_o_live    <= n_o_live;
    end

    assign o_valid           = r_out_vld;
    assign o_running_thread  = 4'(r_o_run);
    assign o_previous_thread = 4'(r_o_prev);
    assign o_switched        = r_o_sw;
    assign o_created_thread  = 4'(r_o_created);
    assign o_status          = r_o_status;
    assign o_woken_count     = 5'(r_o_woken);
    assign o_live_threads    = 5'(r_o_live);

endmodule

>>> dv/tb_round_robin_thread_scheduler_unit.sv
// tb_round_robin_thread_scheduler_unit: self-checking testbench of the thread scheduler
// depends on rrts_pkg and round_robin_thread_scheduler_unit; a local scheduler
// model predicts every result word, which is compared field by field
`timescale 1ns / 1ps

module tb_round_robin_thread_scheduler_unit;
    import rrts_pkg::*;

    localparam int NSLOTS    = 16;
    localparam int IDLE_SLOT = 1;

    // per-slot thread states of the local model
    localparam logic [1:0] TS_FREE     = 2'd0;
    localparam logic [1:0] TS_RUNNABLE = 2'd1;
    localparam logic [1:0] TS_RUNNING  = 2'd2;
    localparam logic [1:0] TS_SLEEPING = 2'd3;

    typedef struct {
        logic [3:0] running;
        logic [3:0] previous;
        logic       switched;
        logic [3:0] created;
        logic [1:0] status;
        logic [4:0] woken;
        logic [4:0] live;
    } t_sched_word;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [2:0]  i_kind;
    logic [63:0] i_wake_tick;
    logic [63:0] i_now_tick;
    logic        o_valid;
    logic        i_ready;
    logic [3:0]  o_running_thread;
    logic [3:0]  o_previous_thread;
    logic        o_switched;
    logic [3:0]  o_created_thread;
    logic [1:0]  o_status;
    logic [4:0]  o_woken_count;
    logic [4:0]  o_live_threads;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [15:0] i_cfg_data;

    round_robin_thread_scheduler_unit #(.MAX_THREADS(NSLOTS)) DUT (.*);

    // scheduler model state
    logic [3:0]  runq[NSLOTS];
    int          runq_head;
    int          runq_fill;
    logic [3:0]  sleep_slot[NSLOTS];
    logic [63:0] sleep_wake[NSLOTS];
    int          sleep_fill;
    logic [1:0]  slot_state[NSLOTS];
    int          cur_slot;
    logic [15:0] slice_count;
    int          live_count;
    bit          preempt_on;
    logic [15:0] slice_reload;

    t_sched_word expected_words[$];
    int          fail_count;
    int          send_idle_pct;
    int          recv_stall_pct;
    int          hold_off_cycles;
    logic [63:0] tick_now;

    // 20 ns clock
    initial i_clk = 1'b0;
    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report_mismatch(string what, int got, int want);
        $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    // ---------------------------------------------------------------
    // local scheduler model
    // ---------------------------------------------------------------
    function automatic void model_reset();
        for (int i = 0; i < NSLOTS; i++) begin
            slot_state[i] = TS_FREE;
            runq[i]       = '0;
            sleep_slot[i] = '0;
            sleep_wake[i] = '0;
        end
        slot_state[0]         = TS_RUNNING;
        slot_state[IDLE_SLOT] = TS_RUNNABLE;
        runq_head    = 0;
        runq_fill    = 0;
        sleep_fill   = 0;
        cur_slot     = 0;
        slice_count  = SLICE_RESET;
        live_count   = 2;
        preempt_on   = 1'b0;
        slice_reload = SLICE_RESET;
    endfunction

    function automatic void runq_push(int slot);
        if (runq_fill < NSLOTS) begin
            runq[(runq_head + runq_fill) % NSLOTS] = slot[3:0];
            runq_fill++;
        end
    endfunction

    // moves the running thread to the queue tail and runs the head, or idle
    function automatic void schedule_step();
        int nxt;
        if (slot_state[cur_slot] == TS_RUNNING) begin
            slot_state[cur_slot] = TS_RUNNABLE;
            if (cur_slot != IDLE_SLOT) runq_push(cur_slot);
        end
        if (runq_fill == 0) begin
            nxt = IDLE_SLOT;
        end else begin
            nxt       = int'(runq[runq_head]);
            runq_head = (runq_head + 1) % NSLOTS;
            runq_fill--;
        end
        slot_state[nxt] = TS_RUNNING;
        slice_count     = slice_reload;
        cur_slot        = nxt;
    endfunction

    // sorted insert, equal wake ticks keep arrival order
    function automatic void sleep_list_add(int slot, logic [63:0] wake);
        int pos;
        pos = 0;
        if (sleep_fill < NSLOTS) begin
            while (pos < sleep_fill && sleep_wake[pos] <= wake) pos++;
            for (int j = sleep_fill; j > pos; j--) begin
                sleep_slot[j] = sleep_slot[j-1];
                sleep_wake[j] = sleep_wake[j-1];
            end
            sleep_slot[pos] = slot[3:0];
            sleep_wake[pos] = wake;
            sleep_fill++;
        end
    endfunction

    function automatic t_sched_word predict_event(logic [2:0] kind, logic [63:0] wake,
                                                  logic [63:0] now);
        t_sched_word w;
        int prev;
        int created;
        int free_slot;
        int woken;
        int s;
        logic [1:0] status;
        prev    = cur_slot;
        created = 0;
        woken   = 0;
        status  = STAT_OK;
        case (kind)
            KIND_CREATE: begin
                free_slot = -1;
                for (int i = NSLOTS - 1; i >= 0; i--)
                    if (slot_state[i] == TS_FREE) free_slot = i;
                if (free_slot < 0) begin
                    status = STAT_NO_SLOT;
                end else begin
                    slot_state[free_slot] = TS_RUNNABLE;
                    runq_push(free_slot);
                    live_count++;
                    created = free_slot;
                end
            end
            KIND_YIELD: schedule_step();
            KIND_SLEEP, KIND_EXIT: begin
                if (cur_slot == IDLE_SLOT) begin
                    status = STAT_REFUSED;
                end else if (kind == KIND_SLEEP) begin
                    slot_state[cur_slot] = TS_SLEEPING;
                    sleep_list_add(cur_slot, wake);
                    schedule_step();
                end else begin
                    slot_state[cur_slot] = TS_FREE;
                    if (live_count > 0) live_count--;
                    schedule_step();
                end
            end
            KIND_TICK: begin
                while (sleep_fill > 0 && sleep_wake[0] <= now) begin
                    s = int'(sleep_slot[0]);
                    for (int j = 0; j < sleep_fill - 1; j++) begin
                        sleep_slot[j] = sleep_slot[j+1];
                        sleep_wake[j] = sleep_wake[j+1];
                    end
                    sleep_fill--;
                    slot_state[s] = TS_RUNNABLE;
                    runq_push(s);
                    woken++;
                end
                if (cur_slot == IDLE_SLOT) begin
                    if (runq_fill > 0) schedule_step();
                end else if (preempt_on) begin
                    slice_count = slice_count - 16'd1;
                    if (slice_count == 16'd0) schedule_step();
                end
            end
            default: ;
        endcase
        w.running  = cur_slot[3:0];
        w.previous = prev[3:0];
        w.switched = (cur_slot != prev);
        w.created  = created[3:0];
        w.status   = status;
        w.woken    = woken[4:0];
        w.live     = live_count[4:0];
        return w;
    endfunction

    // ---------------------------------------------------------------
    // event channel driver: one word per call, prediction on acceptance
    // ---------------------------------------------------------------
    task automatic send_event(logic [2:0] kind, logic [63:0] wake, logic [63:0] now);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            @(negedge i_clk);
            i_valid = 1'b0;
        end
        @(negedge i_clk);
        i_valid     = 1'b1;
        i_kind      = kind;
        i_wake_tick = wake;
        i_now_tick  = now;
        do @(posedge i_clk); while (!o_ready);
        expected_words.push_back(predict_event(kind, wake, now));
    endtask

    task automatic end_burst();
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    // wait until every predicted word came back, then let the block settle
    task automatic wait_drained();
        end_burst();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic write_config(logic [1:0] index, logic [15:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = index;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        if (index == CFG_PREEMPT) preempt_on = data[0];
        else if (index == CFG_SLICE) slice_reload = data;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic set_mode(bit preempt, logic [15:0] slice);
        wait_drained();
        write_config(CFG_PREEMPT, {15'd0, preempt});
        write_config(CFG_SLICE, slice);
    endtask

    // ---------------------------------------------------------------
    // result receiver: random stalls plus an optional long hold-off
    // ---------------------------------------------------------------
    always @(negedge i_clk) begin
        if (hold_off_cycles > 0) begin
            i_ready = 1'b0;
            hold_off_cycles--;
        end else begin
            i_ready = ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge i_clk) begin
        t_sched_word w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                report_mismatch("unexpected result word", 1, 0);
            end else begin
                w = expected_words.pop_front();
                if (o_running_thread !== w.running)
                    report_mismatch("running_thread", int'(o_running_thread),
                                    int'(w.running));
                if (o_previous_thread !== w.previous)
                    report_mismatch("previous_thread", int'(o_previous_thread),
                                    int'(w.previous));
                if (o_switched !== w.switched)
                    report_mismatch("switched", int'(o_switched), int'(w.switched));
                if (o_created_thread !== w.created)
                    report_mismatch("created_thread", int'(o_created_thread),
                                    int'(w.created));
                if (o_status !== w.status)
                    report_mismatch("status", int'(o_status), int'(w.status));
                if (o_woken_count !== w.woken)
                    report_mismatch("woken_count", int'(o_woken_count), int'(w.woken));
                if (o_live_threads !== w.live)
                    report_mismatch("live_threads", int'(o_live_threads), int'(w.live));
            end
        end
    end

    // ---------------------------------------------------------------
    // test tasks
    // ---------------------------------------------------------------

    // idle-thread corner cases, past and far wake ticks, exit of main and slot reuse
    task automatic test_idle_and_sleep();
        send_event(KIND_YIELD, '0, '0);            // main alone keeps running
        send_event(3'd5, '1, '1);                  // unknown kinds do nothing
        send_event(3'd7, '0, '0);
        send_event(KIND_SLEEP, 64'd5, '0);         // main sleeps, idle runs
        send_event(KIND_SLEEP, 64'd3, '0);         // refused for idle
        send_event(KIND_EXIT, '0, '0);             // refused for idle
        send_event(KIND_YIELD, '0, '0);            // idle yields with empty queue
        send_event(KIND_CREATE, '0, '0);           // create while idle, no switch
        send_event(KIND_TICK, '1, 64'd0);          // idle gives way to queued thread
        send_event(KIND_SLEEP, '1, '0);            // wake at the last tick value
        send_event(KIND_CREATE, '0, '0);
        send_event(KIND_TICK, '0, 64'd3);
        send_event(KIND_SLEEP, 64'd0, '0);         // wake tick already past
        send_event(KIND_TICK, '0, 64'd10);         // two sleepers wake in list order
        send_event(KIND_EXIT, '0, '0);
        send_event(KIND_EXIT, '0, '0);             // main exits, idle runs
        send_event(KIND_CREATE, '0, '0);           // slot 0 gets reused
        send_event(KIND_TICK, '0, '1);             // wakes the far sleeper
        wait_drained();
    endtask

    // fill every slot, then two creates too many
    task automatic test_slot_exhaustion();
        repeat (15) send_event(KIND_CREATE, '0, '0);
        send_event(KIND_YIELD, '0, '0);
        wait_drained();
    endtask

    // preemption with shortest, wrapping and longest slice
    task automatic test_preemption();
        set_mode(1'b1, 16'd1);
        repeat (6) send_event(KIND_TICK, '0, 64'd20);
        set_mode(1'b1, 16'd0);
        repeat (4) send_event(KIND_TICK, '0, 64'd21);
        send_event(KIND_YIELD, '0, '0);
        set_mode(1'b1, 16'hffff);
        repeat (4) send_event(KIND_TICK, '0, 64'd22);
        set_mode(1'b0, SLICE_RESET);
    endtask

    task automatic send_random_event();
        int          r;
        logic [2:0]  kind;
        logic [63:0] wake;
        logic [63:0] now;
        r    = $urandom_range(0, 99);
        wake = {$urandom, $urandom};
        now  = {$urandom, $urandom};
        if (r < 18)      kind = KIND_CREATE;
        else if (r < 32) kind = KIND_YIELD;
        else if (r < 58) kind = (r < 46) ? KIND_SLEEP : KIND_EXIT;
        else if (r < 96) kind = KIND_TICK;
        else             kind = 3'($urandom_range(5, 7));
        if (kind == KIND_SLEEP) begin
            // mostly near-future wakeups so that sleepers cycle back
            r = $urandom_range(0, 99);
            if (r < 85)      wake = tick_now + $urandom_range(0, 12);
            else if (r < 90) wake = '0;
            else if (r < 93) wake = '1;
        end else if (kind == KIND_TICK) begin
            if ($urandom_range(0, 99) < 97) begin
                tick_now = tick_now + $urandom_range(0, 3);
                now      = tick_now;
            end
        end
        send_event(kind, wake, now);
    endtask

    // random traffic in one setting, the idling mode changing every quarter
    task automatic test_random_phase(bit preempt, logic [15:0] slice, int count);
        set_mode(preempt, slice);
        for (int m = 0; m < 4; m++) begin
            send_idle_pct  = (m == 1) ? 79 : (m == 3) ? 14 : 0;
            recv_stall_pct = (m == 2) ? 79 : (m == 3) ? 14 : 0;
            repeat (count / 4) send_random_event();
        end
        send_idle_pct  = 0;
        recv_stall_pct = 0;
    endtask

    // receiver holds off while words keep coming, so the input must stall
    task automatic test_backpressure();
        wait_drained();
        @(negedge i_clk);
        hold_off_cycles = 600;
        repeat (40) send_random_event();
        wait_drained();
    endtask

    initial begin
        fail_count      = 0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        tick_now        = 64'd100;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_kind      = KIND_YIELD;
        i_wake_tick = '0;
        i_now_tick  = '0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_PREEMPT;
        i_cfg_data  = '0;
        model_reset();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_idle_and_sleep();
        test_slot_exhaustion();
        test_preemption();
        test_random_phase(1'b0, SLICE_RESET, 300);
        test_random_phase(1'b1, 16'd1, 300);
        test_random_phase(1'b1, 16'd3, 300);
        test_backpressure();
        test_random_phase(1'b1, 16'd0, 300);
        test_random_phase(1'b1, 16'hffff, 300);
        test_random_phase(1'b0, 16'd7, 300);

        wait_drained();
        if (fail_count == 0)
            $display("[round_robin_thread_scheduler_unit] OK");
        else
            $display("[round_robin_thread_scheduler_unit] ERROR");
        $finish;
    end

    // hang guard
    initial begin
        #20_000_000;
        $display("[round_robin_thread_scheduler_unit] ERROR");
        $finish;
    end

endmodule
